### rtl/abb_pkg.sv
package abb_pkg;

  localparam int MaxBodies = 32;
  localparam int CoordBits = 16;
  localparam int SlotW = 5;
  localparam int CntW = 6;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         slot;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_max_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot_out;
    logic [4:0] other_slot;
    logic       pair_valid;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] min_x;
    logic signed [CoordBits-1:0] min_y;
    logic signed [CoordBits-1:0] max_x;
    logic signed [CoordBits-1:0] max_y;
  } box_t;

  // Control handed from the sequencer to every slot cell.
  typedef struct packed {
    logic             clear;
    logic             wr;
    logic [SlotW-1:0] wr_slot;
    logic             rm;
    logic [SlotW-1:0] rm_slot;
    logic             load;
    logic             shift;
  } cell_ctl_t;

  function automatic logic signed [CoordBits-1:0] coord_in(logic signed [15:0] raw);
    logic signed [31:0] s;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    s  = 32'(raw);
    hi = 32'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
    lo = -hi - 32'sd1;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s[CoordBits-1:0];
  endfunction

endpackage

### rtl/abb_cell.sv
module abb_cell
  import abb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SlotW-1:0]     idx,
  input  cell_ctl_t            ctl,
  input  box_t                 new_box,
  input  logic                 prev_occ,
  input  logic [SlotW-1:0]     prev_id,
  input  box_t                 prev_box,
  output logic                 occ,
  output logic                 sh_occ,
  output logic [SlotW-1:0]     sh_id,
  output box_t                 sh_box,
  output box_t                 box
);

  // Hold occupancy and the stored box for this slot.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      occ <= 1'b0;
    end else if (ctl.wr && ctl.wr_slot == idx) begin
      occ <= 1'b1;
    end else if (ctl.rm && ctl.rm_slot == idx) begin
      occ <= 1'b0;
    end
    if (ctl.wr && ctl.wr_slot == idx) begin
      box <= new_box;
    end
  end

  // Scan stage: load own entry, then pass the neighbor's entry along.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh_occ <= occ;
      sh_id  <= idx;
      sh_box <= box;
    end else if (ctl.shift) begin
      sh_occ <= prev_occ;
      sh_id  <= prev_id;
      sh_box <= prev_box;
    end
  end

endmodule

### rtl/aabb_body_table_broadphase.sv
// Brute-force 2D box broadphase over a table of 32 body slots.
// Input channel in_valid/in_ready carries one request beat: add, remove,
// clear or query. Output channel out_valid/out_ready carries result beats;
// the final beat of each request has last set.
// Add, remove and clear load their one result beat into the output register
// from the execute state once that register is free; no new request is
// taken before then. A query of an occupied slot loads every slot cell into
// a shift chain and streams the entries out of the chain end, one per cycle
// while the output register is free. One partner is held back so that the
// final beat can carry last. A query gives one beat per overlapping partner
// in rising slot order (or one beat with no partner).
// One request is handled at a time; in_ready rises again once the last
// result beat of the previous request sits in the output register.
// The output beat sits in a register; while a beat waits with out_ready low
// the scan pauses and nothing is lost or repeated.
// Reset empties the table, the free list and the high-water mark; the
// block accepts a request in the first cycle after reset.
module aabb_body_table_broadphase
  import abb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  in_item_t req;
  logic [CntW-1:0] high_water;
  logic [CntW-1:0] free_count;
  logic [SlotW-1:0] free_stack [MaxBodies];
  logic [CntW-1:0] scan_cnt;
  logic [CntW-1:0] n_found;
  logic held_v;
  logic [SlotW-1:0] held_id;
  box_t me_box;
  cell_ctl_t ctl;
  box_t new_box;
  out_item_t beat;
  logic emit;

  logic             occ     [MaxBodies];
  logic             sh_occ  [MaxBodies];
  logic [SlotW-1:0] sh_id   [MaxBodies];
  box_t             sh_box  [MaxBodies];
  box_t             box     [MaxBodies];

  logic live;
  logic out_free;
  logic [SlotW-1:0] pop_slot;
  logic hit;
  logic take;
  box_t hb;
  logic [SlotW-1:0] hid;
  logic hocc;
  logic scan_step;
  logic scan_end;

  assign new_box.min_x = coord_in(req.box_min_x);
  assign new_box.min_y = coord_in(req.box_min_y);
  assign new_box.max_x = coord_in(req.box_max_x);
  assign new_box.max_y = coord_in(req.box_max_y);

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign live = occ[req.slot];
  assign pop_slot = free_stack[free_count[SlotW-1:0] - SlotW'(1)];

  // Chain end: the entry leaving cell 0.
  assign hb   = sh_box[0];
  assign hid  = sh_id[0];
  assign hocc = sh_occ[0];
  assign hit = hocc && (hid != req.slot) &&
               (me_box.min_x <= hb.max_x) && (hb.min_x <= me_box.max_x) &&
               (me_box.min_y <= hb.max_y) && (hb.min_y <= me_box.max_y);
  assign take = hit && (n_found < CntW'(31));
  assign scan_step = (state == S_SCAN) && out_free;
  assign scan_end = (scan_cnt == CntW'(MaxBodies));

  // Cell control for this cycle.
  always_comb begin
    ctl = '0;
    if (state == S_EXEC && out_free) begin
      case (req.action)
        ACT_ADD: begin
          if (free_count != '0) begin
            ctl.wr = 1'b1;
            ctl.wr_slot = pop_slot;
          end else if (high_water < CntW'(MaxBodies)) begin
            ctl.wr = 1'b1;
            ctl.wr_slot = high_water[SlotW-1:0];
          end
        end
        ACT_REMOVE: begin
          if (live && CntW'(req.slot) < high_water && free_count < CntW'(MaxBodies)) begin
            ctl.rm = 1'b1;
            ctl.rm_slot = req.slot;
          end
        end
        ACT_CLEAR: ctl.clear = 1'b1;
        ACT_QUERY: ctl.load = live;
        default: ;
      endcase
    end
    ctl.shift = scan_step;
  end

  genvar g;
  generate
    for (g = 0; g < MaxBodies; g++) begin : g_cell
      logic             p_occ;
      logic [SlotW-1:0] p_id;
      box_t             p_box;
      if (g == MaxBodies - 1) begin : g_end
        assign p_occ = 1'b0;
        assign p_id  = '0;
        assign p_box = '0;
      end else begin : g_mid
        assign p_occ = sh_occ[g+1];
        assign p_id  = sh_id[g+1];
        assign p_box = sh_box[g+1];
      end
      abb_cell u_cell (
        .clk(clk), .rst(rst), .idx(SlotW'(g)), .ctl(ctl), .new_box(new_box),
        .prev_occ(p_occ), .prev_id(p_id), .prev_box(p_box),
        .occ(occ[g]), .sh_occ(sh_occ[g]), .sh_id(sh_id[g]), .sh_box(sh_box[g]),
        .box(box[g])
      );
    end
  endgenerate

  // Next state and the result beat to load.
  always_comb begin
    beat = '{status: ST_DONE, slot_out: req.slot, other_slot: '0,
             pair_valid: 1'b0, last: 1'b1};
    emit = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          state_next = S_IDLE;
          case (req.action)
            ACT_ADD: begin
              if (free_count != '0) begin
                beat.slot_out = pop_slot;
              end else if (high_water < CntW'(MaxBodies)) begin
                beat.slot_out = high_water[SlotW-1:0];
              end else begin
                beat.status = ST_FULL;
                beat.slot_out = '0;
              end
            end
            ACT_REMOVE: begin
              if (!ctl.rm) beat.status = ST_IGNORED;
            end
            ACT_CLEAR: beat.slot_out = '0;
            ACT_QUERY: begin
              if (live) begin
                emit = 1'b0;
                state_next = S_SCAN;
              end else begin
                beat.status = ST_IGNORED;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_step) begin
          if (scan_end) begin
            // Flush the held partner as the final beat.
            emit = 1'b1;
            state_next = S_IDLE;
            beat.other_slot = held_v ? held_id : '0;
            beat.pair_valid = held_v;
          end else if (take && held_v) begin
            // A newer partner arrived: release the held one.
            emit = 1'b1;
            beat.other_slot = held_id;
            beat.pair_valid = 1'b1;
            beat.last = 1'b0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer, free list and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      high_water <= '0;
      free_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= emit || (out_valid && !out_ready);
      if (emit) out_data <= beat;
      if (state == S_IDLE && in_valid) req <= in_data;
      if (ctl.clear) begin
        high_water <= '0;
        free_count <= '0;
      end else if (ctl.rm) begin
        free_stack[free_count[SlotW-1:0]] <= req.slot;
        free_count <= free_count + CntW'(1);
      end else if (ctl.wr) begin
        if (free_count != '0) free_count <= free_count - CntW'(1);
        else high_water <= high_water + CntW'(1);
      end
      if (ctl.load) begin
        me_box <= box[req.slot];
        scan_cnt <= '0;
        n_found <= '0;
        held_v <= 1'b0;
      end else if (scan_step && !scan_end) begin
        scan_cnt <= scan_cnt + CntW'(1);
        if (take) begin
          n_found <= n_found + CntW'(1);
          held_v <= 1'b1;
          held_id <= hid;
        end
      end
    end
  end

endmodule
